@@ sv/lts_pkg.sv @@
// Package for the LRU tag store: field widths, operation codes and
// default parameter values. No dependencies.
package lts_pkg;

  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 4;
  localparam int STAMP_W = 32;

  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 64;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

endpackage

@@ sv/lru_tag_store.sv @@
// Fully associative tag store with LRU replacement by access stamps.
// Depends on lts_pkg for widths, operation codes and parameter defaults.
//
//   channel  direction  handshake              payload
//   request  in         req_valid / req_ready  operation, key
//   response out        rsp_valid / rsp_ready  hit, slot, evicted
//
// A request is accepted only in the idle state, so the next one waits until this
// one is through: the key and stamp memories are read one entry per cycle
// through a single compare unit, with the compare in the cycle after the read.
// A final write cycle updates the chosen entry and loads the response
// register; it waits there if an earlier response has not been taken.
// Reset clears the valid bits, the stamp counter and all control state;
// no clearing pass is needed.
module lru_tag_store #(
  parameter int ENTRIES  = lts_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lts_pkg::DEF_KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       operation,
  input  logic [lts_pkg::KEY_W-1:0]  key,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic                       hit,
  output logic [lts_pkg::SLOT_W-1:0] slot,
  output logic                       evicted
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int EXT_W  = IDX_W + lts_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [KEY_BITS-1:0]         key_mem   [ENTRIES];
  logic [lts_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]          entry_valid;
  logic [lts_pkg::STAMP_W-1:0] stamp_counter;

  logic                        req_op;
  logic [KEY_BITS-1:0]         req_key;

  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_active;
  logic [IDX_W-1:0]            cmp_idx;
  logic                        cmp_active;
  logic [KEY_BITS-1:0]         rd_key;
  logic [lts_pkg::STAMP_W-1:0] rd_stamp;

  logic                        found, found_next;
  logic [IDX_W-1:0]            found_idx, found_idx_next;
  logic                        free_found, free_found_next;
  logic [IDX_W-1:0]            free_idx, free_idx_next;
  logic [lts_pkg::STAMP_W-1:0] best_stamp, best_stamp_next;
  logic [IDX_W-1:0]            best_idx, best_idx_next;

  logic                        accept;
  logic                        finish;
  logic                        do_write;
  logic [IDX_W-1:0]            sel_idx;
  logic                        sel_write;
  logic [EXT_W-1:0]            sel_ext;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = cmp_active && (cmp_idx == LAST_IDX);
  assign do_write  = (state == S_WRITE) && (!rsp_valid || rsp_ready);

  // One entry per cycle through the shared compare and minimum unit.
  always_comb begin
    found_next      = found;
    found_idx_next  = found_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    best_stamp_next = best_stamp;
    best_idx_next   = best_idx;
    if (cmp_active) begin
      if (req_op == lts_pkg::OP_LOOKUP) begin
        if (!found && entry_valid[cmp_idx] && (rd_key == req_key)) begin
          found_next     = 1'b1;
          found_idx_next = cmp_idx;
        end
      end else begin
        if (!free_found && !entry_valid[cmp_idx]) begin
          free_found_next = 1'b1;
          free_idx_next   = cmp_idx;
        end
        // Strict less-than keeps the lowest index among equal stamps.
        if ((cmp_idx == '0) || (rd_stamp < best_stamp)) begin
          best_stamp_next = rd_stamp;
          best_idx_next   = cmp_idx;
        end
      end
    end
  end

  always_comb begin
    if (req_op == lts_pkg::OP_LOOKUP) begin
      sel_idx   = found ? found_idx : '0;
      sel_write = found;
    end else begin
      sel_idx   = free_found ? free_idx : best_idx;
      sel_write = 1'b1;
    end
    sel_ext = EXT_W'(sel_idx);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (finish) state_next = S_WRITE;
      S_WRITE: if (do_write) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_valid   <= '0;
      stamp_counter <= '0;
      rd_active     <= 1'b0;
      cmp_active    <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      cmp_active <= rd_active;
      if (accept) begin
        rd_active <= 1'b1;
      end else if (rd_active && (rd_idx == LAST_IDX)) begin
        rd_active <= 1'b0;
      end
      if (do_write) begin
        rsp_valid <= 1'b1;
        if (sel_write) begin
          stamp_counter <= stamp_counter + 1'b1;
        end
        if (req_op == lts_pkg::OP_INSERT) begin
          entry_valid[sel_idx] <= 1'b1;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx    <= rd_idx;
    found_idx  <= found_idx_next;
    free_idx   <= free_idx_next;
    best_stamp <= best_stamp_next;
    best_idx   <= best_idx_next;
    if (accept) begin
      req_op     <= operation;
      req_key    <= key[KEY_BITS-1:0];
      rd_idx     <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      found      <= found_next;
      free_found <= free_found_next;
      if (rd_active) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
    if (do_write) begin
      hit     <= (req_op == lts_pkg::OP_LOOKUP) && found;
      slot    <= sel_ext[lts_pkg::SLOT_W-1:0];
      evicted <= (req_op == lts_pkg::OP_INSERT) && !free_found;
    end
  end

  // Key and stamp memories: one registered read, one write per cycle.
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[rd_idx];
    rd_stamp <= stamp_mem[rd_idx];
    if (do_write && sel_write) begin
      stamp_mem[sel_idx] <= stamp_counter;
    end
    if (do_write && (req_op == lts_pkg::OP_INSERT)) begin
      key_mem[sel_idx] <= req_key;
    end
  end

endmodule

@@ verif/lru_tag_store_tb.sv @@
// Self-checking testbench for lru_tag_store: directed and random lookups and inserts,
// each response checked against a built-in LRU tag predictor.
// Depends on lts_pkg and the lru_tag_store RTL.
module lru_tag_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ENTRIES     = lts_pkg::DEF_ENTRIES;
  localparam int N_KEY_BITS    = lts_pkg::DEF_KEY_BITS;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEM_CYCLES   = N_ENTRIES + 3;
  localparam int SETTLE_CYCLES = 2 * ITEM_CYCLES;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 385;
  localparam int HOLD_CYCLES   = 300;
  localparam int POOL_DEPTH    = 32;
  localparam logic [lts_pkg::KEY_W-1:0] KEY_MASK =
    {lts_pkg::KEY_W{1'b1}} >> (lts_pkg::KEY_W - N_KEY_BITS);

  typedef struct packed {
    logic                       hit;
    logic [lts_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
  } slot_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  logic                       operation = lts_pkg::OP_LOOKUP;
  logic [lts_pkg::KEY_W-1:0]  key = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  logic                       hit;
  logic [lts_pkg::SLOT_W-1:0] slot;
  logic                       evicted;

  // Predictor state: a shadow copy of the tag store.
  logic                        tag_valid [N_ENTRIES];
  logic [lts_pkg::KEY_W-1:0]   tag_key   [N_ENTRIES];
  logic [lts_pkg::STAMP_W-1:0] tag_stamp [N_ENTRIES];
  logic [lts_pkg::STAMP_W-1:0] access_clock;

  slot_report_t expected_reports[$];
  logic [lts_pkg::KEY_W-1:0] key_pool [POOL_DEPTH];

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_left     = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int lookup_hits   = 0;
  int lookup_misses = 0;
  int inserts_done  = 0;
  int evictions     = 0;

  lru_tag_store #(
    .ENTRIES (N_ENTRIES),
    .KEY_BITS(N_KEY_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .operation(operation),
    .key      (key),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .hit      (hit),
    .slot     (slot),
    .evicted  (evicted)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Response side: a long hold-off when requested, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin : check_response
    slot_report_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: response with nothing pending: hit=%0b slot=%0d evicted=%0b",
                 $time, hit, slot, evicted);
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, hit);
          error_count++;
        end
        if (slot !== want.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d", $time, want.slot, slot);
          error_count++;
        end
        if (evicted !== want.evicted) begin
          $display("%0t: evicted mismatch: expected %0b, actual %0b",
                   $time, want.evicted, evicted);
          error_count++;
        end
      end
    end
  end

  function automatic void clear_tag_model();
    for (int i = 0; i < N_ENTRIES; i++) begin
      tag_valid[i] = 1'b0;
      tag_key[i]   = '0;
      tag_stamp[i] = '1;
    end
    access_clock = '0;
  endfunction

  // Applies one transaction to the shadow store and returns the response it must produce.
  function automatic slot_report_t predict_tag_access(logic op,
                                                      logic [lts_pkg::KEY_W-1:0] k);
    slot_report_t rep;
    logic [lts_pkg::KEY_W-1:0] masked;
    int victim;
    masked = k & KEY_MASK;
    rep = '0;
    if (op == lts_pkg::OP_LOOKUP) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (tag_valid[i] && tag_key[i] == masked) begin
          tag_stamp[i] = access_clock;
          access_clock = access_clock + 1'b1;
          rep.hit  = 1'b1;
          rep.slot = lts_pkg::SLOT_W'(i);
          break;
        end
      end
      if (rep.hit) lookup_hits++;
      else lookup_misses++;
    end else begin
      victim = -1;
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (victim < 0 && !tag_valid[i]) victim = i;
      end
      // With every entry valid, the oldest stamp loses; ties go to the lower index.
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < N_ENTRIES; i++) begin
          if (tag_stamp[i] < tag_stamp[victim]) victim = i;
        end
      end
      rep.evicted       = tag_valid[victim];
      rep.slot          = lts_pkg::SLOT_W'(victim);
      tag_key[victim]   = masked;
      tag_valid[victim] = 1'b1;
      tag_stamp[victim] = access_clock;
      access_clock      = access_clock + 1'b1;
      inserts_done++;
      if (rep.evicted) evictions++;
    end
    return rep;
  endfunction

  task automatic send_request(input logic op, input logic [lts_pkg::KEY_W-1:0] k);
    req_valid <= 1'b1;
    operation <= op;
    key       <= k;
    do @(posedge clk); while (!req_ready);
    expected_reports.push_back(predict_tag_access(op, k));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, ITEM_CYCLES)) @(posedge clk);
    end
  endtask

  // Stops offering requests and waits until every pending response has been taken.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_lookup();
    send_request(lts_pkg::OP_LOOKUP, '0);
    send_request(lts_pkg::OP_LOOKUP, '1);
    wait_drained();
  endtask

  task automatic test_basic_hit();
    send_request(lts_pkg::OP_INSERT, '0);
    send_request(lts_pkg::OP_INSERT, '1);
    send_request(lts_pkg::OP_LOOKUP, '0);
    send_request(lts_pkg::OP_LOOKUP, '1);
    send_request(lts_pkg::OP_LOOKUP, {1'b1, {(lts_pkg::KEY_W-1){1'b0}}});
    wait_drained();
  endtask

  // Fills the remaining entries, refreshes the first one, then forces an eviction.
  task automatic test_fill_and_evict();
    for (int i = 2; i < N_ENTRIES; i++)
      send_request(lts_pkg::OP_INSERT, {$urandom, $urandom});
    send_request(lts_pkg::OP_LOOKUP, '0);
    send_request(lts_pkg::OP_INSERT, 64'h0123_4567_89ab_cdef);
    wait_drained();
  endtask

  // A second copy of a stored key lands elsewhere; lookups still find the lower entry.
  task automatic test_duplicate_insert();
    send_request(lts_pkg::OP_INSERT, '0);
    send_request(lts_pkg::OP_LOOKUP, '0);
    wait_drained();
  endtask

  // The response side holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 6; i++)
      send_request(($urandom_range(1) != 0) ? lts_pkg::OP_INSERT : lts_pkg::OP_LOOKUP,
                   key_pool[$urandom_range(7)]);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int pool_size;
    int pick;
    int choice;
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    pool_size = 8;
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = {$urandom, $urandom};
    for (int n = 0; n < count; n++) begin
      // Vary the working set so it sometimes fits the store and sometimes thrashes it.
      if (n % 50 == 0) begin
        case ($urandom_range(3))
          0: pool_size = 8;
          1: pool_size = 14;
          2: pool_size = 20;
          default: pool_size = POOL_DEPTH;
        endcase
      end
      pick   = $urandom_range(pool_size - 1);
      choice = $urandom_range(99);
      if (choice < 45)
        send_request(lts_pkg::OP_LOOKUP, key_pool[pick]);
      else if (choice < 80)
        send_request(lts_pkg::OP_INSERT, key_pool[pick]);
      else if (choice < 90)
        send_request(lts_pkg::OP_LOOKUP,
                     key_pool[pick] ^ (64'h1 << $urandom_range(lts_pkg::KEY_W - 1)));
      else
        send_request(($urandom_range(1) != 0) ? lts_pkg::OP_INSERT : lts_pkg::OP_LOOKUP,
                     {$urandom, $urandom});
    end
    wait_drained();
  endtask

  initial begin
    clear_tag_model();
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = {$urandom, $urandom};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_lookup();
    test_basic_hit();
    test_fill_and_evict();
    test_duplicate_insert();
    test_backpressure();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(66, 0, PHASE_ITEMS);
    test_random_traffic(0, 66, PHASE_ITEMS);
    test_random_traffic(11, 11, PHASE_ITEMS);

    if (expected_reports.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_reports.size());
      error_count++;
    end
    $display("Ran %0d lookups (%0d hits, %0d misses) and %0d inserts, %0d of them evicting,",
             lookup_hits + lookup_misses, lookup_hits, lookup_misses, inserts_done, evictions);
    $display("under steady flow, sender gaps, response stalls and a long response hold-off.");
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
